[hdl/pdtas_pkg.sv]
// Package for the pad double-tap action scheduler.
// Holds the item struct, the operation, action and command codes, and a helper.
// No dependencies.
`timescale 1ns / 1ps

package pdtas_pkg;

  // Operation that the front end assigns to an accepted item
  localparam logic [1:0] OP_PRESS = 2'd0;  // press on a live engine and a slot in range
  localparam logic [1:0] OP_DROP  = 2'd1;  // press that is not handled
  localparam logic [1:0] OP_TICK  = 2'd2;  // timer tick, walks all slots

  // Pending tap actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_FRESH     = 2'd1;
  localparam logic [1:0] ACT_STOP_PLAY = 2'd2;
  localparam logic [1:0] ACT_STOP_REC  = 2'd3;

  // Recorder commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_OVERDUB   = 3'd1;
  localparam logic [2:0] CMD_START_REC = 3'd2;
  localparam logic [2:0] CMD_STOP_REC  = 3'd3;
  localparam logic [2:0] CMD_STOP_PLAY = 3'd4;

  localparam logic [15:0] WINDOW_RST = 16'd300;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  slot;
    logic [31:0] now;
    logic        engine;
    logic        recording;
    logic        overdubbing;
    logic        has_events;
    logic        playing;
  } item_t;

  function automatic logic [2:0] deferred_cmd(input logic [1:0] act);
    logic [2:0] c;
    unique case (act)
      ACT_FRESH:     c = CMD_START_REC;
      ACT_STOP_PLAY: c = CMD_STOP_PLAY;
      ACT_STOP_REC:  c = CMD_STOP_REC;
      default:       c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

[hdl/pdtas_front.sv]
// Front end: takes input transfers and classifies them into queue items.
// Depends on pdtas_pkg.
`timescale 1ns / 1ps

module pdtas_front import pdtas_pkg::*; #(
  parameter int PAD_SLOTS = 4
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [1:0]  in_pad_slot,
  input  logic [31:0] in_now_ms,
  input  logic        in_engine_present,
  input  logic        in_slot_recording,
  input  logic        in_slot_overdubbing,
  input  logic        in_slot_has_events,
  input  logic        in_slot_playing,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic slot_in_range;

  assign slot_in_range = ({30'd0, in_pad_slot} < 32'(PAD_SLOTS));
  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;

  always_comb begin
    q_item.slot        = in_pad_slot;
    q_item.now         = in_now_ms;
    q_item.engine      = in_engine_present;
    q_item.recording   = in_slot_recording;
    q_item.overdubbing = in_slot_overdubbing;
    q_item.has_events  = in_slot_has_events;
    q_item.playing     = in_slot_playing;
    priority if (in_req_type) begin
      q_item.op = OP_TICK;
    end else if (in_engine_present && slot_in_range) begin
      q_item.op = OP_PRESS;
    end else begin
      q_item.op = OP_DROP;
    end
  end

endmodule

[hdl/pdtas_queue.sv]
// Two-entry queue between front and back end.
// Depends on pdtas_pkg for the item type.
`timescale 1ns / 1ps

module pdtas_queue import pdtas_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/pdtas_back.sv]
// Back end: holds the pending action table and the window register,
// executes presses and walks slots on ticks. Depends on pdtas_pkg.
`timescale 1ns / 1ps

module pdtas_back import pdtas_pkg::*; #(
  parameter int PAD_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_target_slot,
  output logic [2:0]  out_command,
  output logic        out_press_handled,
  output logic        out_last_result
);

  localparam int SW   = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;
  localparam int NRES = (PAD_SLOTS < 4) ? PAD_SLOTS : 4;

  logic [1:0]    act_r [PAD_SLOTS];
  logic [31:0]   dl_r  [PAD_SLOTS];
  logic [15:0]   win_r;
  logic [SW-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_slot_r;
  logic [2:0]    out_cmd_r;
  logic          out_handled_r;
  logic          out_last_r;

  logic          is_tick, emit, done, out_free, step_go;
  logic [SW-1:0] idx;
  logic [1:0]    cur_act;
  logic [31:0]   diff;
  logic          wr_en;
  logic [1:0]    wr_act;
  logic [31:0]   wr_dl;
  logic [1:0]    res_slot;
  logic [2:0]    res_cmd;
  logic          res_handled;
  logic          res_last;

  assign cfg_ready = 1'b1;

  assign is_tick  = (q_item.op == OP_TICK);
  assign emit     = !is_tick || ({{(32-SW){1'b0}}, cnt_r} < 32'(NRES));
  assign done     = !is_tick || (cnt_r == SW'(PAD_SLOTS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign step_go  = q_valid && (out_free || !emit);
  assign q_pop    = step_go && done;

  assign idx     = is_tick ? cnt_r : SW'(q_item.slot);
  assign cur_act = act_r[idx];
  assign diff    = dl_r[idx] - q_item.now;

  always_comb begin
    wr_en       = 1'b0;
    wr_act      = ACT_NONE;
    wr_dl       = q_item.now + {16'd0, win_r};
    res_slot    = q_item.slot;
    res_cmd     = CMD_NONE;
    res_handled = 1'b0;
    res_last    = 1'b1;
    unique case (q_item.op)
      OP_PRESS: begin
        wr_en       = 1'b1;
        res_handled = 1'b1;
        // live entry whose deadline has not passed: second tap
        priority if (cur_act != ACT_NONE && !diff[31]) begin
          res_cmd = CMD_OVERDUB;
        end else if (q_item.recording) begin
          if (q_item.overdubbing) begin
            wr_act = ACT_STOP_REC;
          end else begin
            res_cmd = CMD_STOP_REC;
          end
        end else if (!q_item.has_events) begin
          res_cmd = CMD_START_REC;
        end else begin
          wr_act = q_item.playing ? ACT_STOP_PLAY : ACT_FRESH;
        end
      end
      OP_TICK: begin
        res_slot = 2'(cnt_r);
        res_last = (cnt_r == SW'(NRES - 1));
        priority if (!q_item.engine) begin
          wr_en = 1'b1;
        end else if (cur_act == ACT_NONE || diff == 32'd0 || diff[31]) begin
          wr_en   = 1'b1;
          res_cmd = deferred_cmd(cur_act);
        end else begin
          wr_en = 1'b0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (step_go && is_tick) begin
      cnt_nxt = done ? '0 : cnt_r + SW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (step_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      win_r       <= WINDOW_RST;
      for (int i = 0; i < PAD_SLOTS; i++) begin
        act_r[i] <= ACT_NONE;
      end
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        win_r <= cfg_data;
      end
      if (step_go && wr_en) begin
        act_r[idx] <= wr_act;
      end
    end
  end

  // deadline is only looked at while its action is live, so no reset
  always_ff @(posedge clk) begin
    if (step_go && wr_en) begin
      dl_r[idx] <= wr_dl;
    end
    if (step_go && emit) begin
      out_slot_r    <= res_slot;
      out_cmd_r     <= res_cmd;
      out_handled_r <= res_handled;
      out_last_r    <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target_slot   = out_slot_r;
  assign out_command       = out_cmd_r;
  assign out_press_handled = out_handled_r;
  assign out_last_result   = out_last_r;

  // a slot walk in progress only happens on a tick at the queue head
  a_walk_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> q_valid && is_tick)
    else $error("slot walk without a tick at queue head");

  // a handled press always ends its item
  a_press_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_handled_r |-> out_last_r)
    else $error("handled press result not marked last");

  // ticks never report a press as handled
  a_tick_unhandled: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && emit && is_tick |=> !out_handled_r)
    else $error("tick result marked handled");

  // no command code beyond stop playback
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cmd_r <= CMD_STOP_PLAY)
    else $error("command code out of range");

endmodule

[hdl/pad_double_tap_action_scheduler.sv]
// Pad double-tap action scheduler, top level.
// Front end classifies items, a two-entry queue decouples it from the back end.
// An input transfer goes into a queue entry, then its result into the output register.
// A press is one back-end step; a tick walks the slots in turn, set by the single
// read/write port on the pending action table. A step with a result waits while one is untaken.
// Reset (rst_n low, synchronous): queue empty, all actions none, window 300 ms.
`timescale 1ns / 1ps

module pad_double_tap_action_scheduler import pdtas_pkg::*; #(
  parameter int PAD_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [1:0]  in_pad_slot,
  input  logic [31:0] in_now_ms,
  input  logic        in_engine_present,
  input  logic        in_slot_recording,
  input  logic        in_slot_overdubbing,
  input  logic        in_slot_has_events,
  input  logic        in_slot_playing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_target_slot,
  output logic [2:0]  out_command,
  output logic        out_press_handled,
  output logic        out_last_result
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t push_item, head_item;

  pdtas_front #(.PAD_SLOTS(PAD_SLOTS)) u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_pad_slot         (in_pad_slot),
    .in_now_ms           (in_now_ms),
    .in_engine_present   (in_engine_present),
    .in_slot_recording   (in_slot_recording),
    .in_slot_overdubbing (in_slot_overdubbing),
    .in_slot_has_events  (in_slot_has_events),
    .in_slot_playing     (in_slot_playing),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_item              (push_item)
  );

  pdtas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  pdtas_back #(.PAD_SLOTS(PAD_SLOTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_item            (head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target_slot   (out_target_slot),
    .out_command       (out_command),
    .out_press_handled (out_press_handled),
    .out_last_result   (out_last_result)
  );

endmodule
